// File: hw/rtl/bsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bias stability detector package
// Word types, internal stage types and fixed-point constants that the
// input stage, the tracker and the top level share.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int AXES      = 3;
    localparam int TS_W      = 64;
    localparam int BIAS_W    = 24;
    localparam int VAR_W     = 32;
    localparam int LIM_W     = 23;
    localparam int LIM_SQ_W  = 2 * LIM_W;
    localparam int DIFF_W    = BIAS_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int DSQ_W     = SQ_W + 2;
    localparam int DSQ100_W  = DSQ_W + 7;
    localparam int RATIO_W   = VAR_W + 7;

    localparam logic [VAR_W-1:0]   VAR_LIMIT = 32'd1099511628;
    localparam logic [RATIO_W-1:0] VAR_RATIO = 39'd100;
    localparam logic [TS_W-1:0]    STEADY_US = 64'd10000000;

    typedef struct packed {
        logic [TS_W-1:0]          timestamp_us;
        logic signed [BIAS_W-1:0] bias_x;
        logic signed [BIAS_W-1:0] bias_y;
        logic signed [BIAS_W-1:0] bias_z;
        logic [VAR_W-1:0]         variance_x;
        logic [VAR_W-1:0]         variance_y;
        logic [VAR_W-1:0]         variance_z;
        logic [LIM_W-1:0]         drift_limit;
        logic                     estimate_ok;
        logic                     learning_ok;
        logic                     air_entry;
    } bsd_in_t;

    typedef struct packed {
        logic            stable;
        logic [TS_W-1:0] stable_time_us;
        logic            estimate_valid;
    } bsd_out_t;

    typedef struct packed {
        logic [TS_W-1:0]             timestamp_us;
        logic [AXES-1:0][BIAS_W-1:0] bias;
        logic [LIM_SQ_W-1:0]         limit_sq;
        logic                        estimate_valid;
        logic                        learning_ok;
        logic                        air_entry;
    } bsd_item_t;

    typedef struct packed {
        logic      valid;
        bsd_item_t item;
    } bsd_stage_t;

endpackage

// File: hw/rtl/bsd_input_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bias stability detector input stage
// Registers an accepted word together with its variance verdict and the
// squared bias limit.
// ----------------------------------------------------------------------------
module bsd_input_stage
    import bsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  bsd_in_t    s_data,
    input  logic       advance,
    output bsd_stage_t stage
);

    logic            valid_reg;
    logic            valid_next;
    bsd_item_t       item_reg;
    logic            load;
    logic [VAR_W-1:0] vmax;
    logic [VAR_W-1:0] vmin;
    logic [RATIO_W-1:0] vmin_scaled;
    logic            var_ok;
    logic [LIM_SQ_W-1:0] limit_sq;

    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        vmax = s_data.variance_x;
        vmin = s_data.variance_x;
        if (s_data.variance_y > vmax) begin
            vmax = s_data.variance_y;
        end
        if (s_data.variance_z > vmax) begin
            vmax = s_data.variance_z;
        end
        if (s_data.variance_y < vmin) begin
            vmin = s_data.variance_y;
        end
        if (s_data.variance_z < vmin) begin
            vmin = s_data.variance_z;
        end
        vmin_scaled = RATIO_W'(vmin) * VAR_RATIO;
        var_ok      = (vmax < VAR_LIMIT) && (RATIO_W'(vmax) < vmin_scaled);
        limit_sq    = LIM_SQ_W'(s_data.drift_limit) * LIM_SQ_W'(s_data.drift_limit);
    end

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.timestamp_us   <= s_data.timestamp_us;
            item_reg.bias           <= {s_data.bias_z, s_data.bias_y, s_data.bias_x};
            item_reg.limit_sq       <= limit_sq;
            item_reg.estimate_valid <= s_data.estimate_ok && var_ok;
            item_reg.learning_ok    <= s_data.learning_ok;
            item_reg.air_entry      <= s_data.air_entry;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// File: hw/rtl/bsd_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bias stability detector tracker
// Holds the reference bias and the steady-time total, updates them for one
// word per cycle unless the result waits, and registers the result word.
// ----------------------------------------------------------------------------
module bsd_tracker
    import bsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  bsd_stage_t stage,
    output logic       advance,
    output logic       m_valid,
    input  logic       m_ready,
    output bsd_out_t   m_data
);

    logic [AXES-1:0][BIAS_W-1:0] ref_bias_reg;
    logic [AXES-1:0][BIAS_W-1:0] ref_bias_next;
    logic [TS_W-1:0]             last_time_reg;
    logic [TS_W-1:0]             last_time_next;
    logic [TS_W-1:0]             steady_total_reg;
    logic [TS_W-1:0]             steady_total_next;
    logic                        available_reg;
    logic                        available_next;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    bsd_out_t                    m_data_reg;

    logic [AXES-1:0][BIAS_W-1:0] ref_eff;
    logic [TS_W-1:0]             last_eff;
    logic [TS_W-1:0]             total_eff;
    logic                        avail_eff;
    logic signed [DIFF_W-1:0]    diff [AXES];
    logic signed [SQ_W-1:0]      sq [AXES];
    logic [DSQ_W-1:0]            dsq;
    logic [DSQ100_W-1:0]         dsq100;
    logic                        near;
    logic [TS_W-1:0]             dt;
    logic [TS_W:0]               sum;
    logic [TS_W-1:0]             sum_sat;
    bsd_item_t                   it;

    assign it      = stage.item;
    assign advance = stage.valid && (!m_valid_reg || m_ready);

    always_comb begin
        ref_eff   = it.air_entry ? '0 : ref_bias_reg;
        last_eff  = it.air_entry ? '0 : last_time_reg;
        total_eff = it.air_entry ? '0 : steady_total_reg;
        avail_eff = it.air_entry ? 1'b0 : available_reg;

        dsq = '0;
        for (int i = 0; i < AXES; i++) begin
            diff[i] = $signed({ref_eff[i][BIAS_W-1], ref_eff[i]})
                    - $signed({it.bias[i][BIAS_W-1], it.bias[i]});
            sq[i]   = diff[i] * diff[i];
            dsq     = dsq + DSQ_W'($unsigned(sq[i]));
        end
        dsq100 = DSQ100_W'({dsq, 6'b0}) + DSQ100_W'({dsq, 5'b0})
               + DSQ100_W'({dsq, 2'b0});
        near   = dsq100 <= DSQ100_W'(it.limit_sq);

        dt      = it.timestamp_us - last_eff;
        sum     = {1'b0, total_eff} + {1'b0, dt};
        sum_sat = sum[TS_W] ? '1 : sum[TS_W-1:0];
    end

    always_comb begin
        ref_bias_next     = ref_eff;
        last_time_next    = last_eff;
        steady_total_next = total_eff;
        available_next    = avail_eff;
        if (it.estimate_valid && it.learning_ok) begin
            last_time_next = it.timestamp_us;
            if (near) begin
                if (last_eff != '0) begin
                    if (it.timestamp_us > last_eff) begin
                        steady_total_next = sum_sat;
                    end else begin
                        steady_total_next = '0;
                        available_next    = 1'b0;
                    end
                end
                if (steady_total_next > STEADY_US) begin
                    available_next = 1'b1;
                end
            end else begin
                steady_total_next = '0;
                ref_bias_next     = it.bias;
                available_next    = 1'b0;
            end
        end else begin
            last_time_next = '0;
            if (!it.estimate_valid && total_eff != '0) begin
                ref_bias_next     = '0;
                steady_total_next = '0;
                available_next    = 1'b0;
            end
        end
    end

    always_comb begin
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_bias_reg     <= '0;
            last_time_reg    <= '0;
            steady_total_reg <= '0;
            available_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                ref_bias_reg     <= ref_bias_next;
                last_time_reg    <= last_time_next;
                steady_total_reg <= steady_total_next;
                available_reg    <= available_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg.stable         <= available_next;
            m_data_reg.stable_time_us <= steady_total_next;
            m_data_reg.estimate_valid <= it.estimate_valid;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hw/rtl/bias_stability_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bias stability detector
// Tracks a three-axis bias estimate against a stored reference and reports
// when it has held within a tenth of the bias limit for over ten seconds.
// ----------------------------------------------------------------------------
// Each input word carries a timestamp, the bias estimate, its variances, the
// bias limit and the estimate, learning and air-entry flags. Every input
// word yields exactly one result word with the stable flag, the accumulated
// steady time and the estimate verdict, in input order.
// Both channels use valid and ready. A word is held first in an input
// register, where the variance check and the squared limit are formed, and
// then passes through the tracker, which updates the reference and the
// steady-time total and loads the result register in the same cycle.
// Without a stall, the word moves from the input register into the result
// register, and m_valid rises when the result register loads. Throughput
// is one word per cycle while the receiver takes results, set by the
// tracker, which reads and writes the stored state for each word.
// A new word is accepted while a finished result waits to be taken; when
// the receiver stalls, the result register and the input register both
// hold, and s_ready drops once both are full.
// Synchronous reset clears the reference, the last timestamp, the total and
// the stable flag, and empties both registers.
// ----------------------------------------------------------------------------
module bias_stability_detector
    import bsd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  bsd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output bsd_out_t m_data
);

    bsd_stage_t stage;
    logic       advance;

    bsd_input_stage u_input_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .advance (advance),
        .stage   (stage)
    );

    bsd_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stage   (stage),
        .advance (advance),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
